FILE: hdl/five_tuple_flow_table_with_aging_top_defines.svh
`ifndef FIVE_TUPLE_FLOW_TABLE_WITH_AGING_TOP_DEFINES_SVH
`define FIVE_TUPLE_FLOW_TABLE_WITH_AGING_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FT_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FT_ASSERT(label, clk, rst_n, prop, msg)
`define FT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: hdl/ftfta_pkg.sv
package ftfta_pkg;
	localparam int FLOW_ENTRIES_DEF = 64;
	localparam int TIME_BITS_DEF = 40;
	localparam int CFG_BITS = 40;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [CFG_BITS-1:0] REPORT_INTERVAL_RST = CFG_BITS'(4000000);
	localparam logic [CFG_BITS-1:0] REMOVE_AGE_RST = CFG_BITS'(16000000);
	localparam logic REG_REPORT_INTERVAL = 1'b0;
	localparam logic REG_REMOVE_AGE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] sip;
		logic [31:0] dip;
		logic [7:0] proto;
		logic [31:0] ports;
	} key_t;

	typedef struct packed {
		logic lookup;
		logic sweep;
		logic write;
		logic refresh;
		logic reported;
	} cell_cmd_t;
endpackage

FILE: hdl/ftfta_cell.sv
module ftfta_cell #(
	parameter int TIME_BITS = ftfta_pkg::TIME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input ftfta_pkg::cell_cmd_t cmd,
	input logic sel,
	input ftfta_pkg::key_t key,
	input logic [TIME_BITS-1:0] now,
	input logic [TIME_BITS-1:0] remove_age,
	input logic free_in,
	output logic free_out,
	output logic valid,
	output logic match,
	output logic [TIME_BITS-1:0] last_reported
);
	logic valid_q;
	ftfta_pkg::key_t key_q;
	logic [TIME_BITS-1:0] heard_q;
	logic [TIME_BITS-1:0] rep_q;
	logic [TIME_BITS-1:0] age;

	assign age = now - heard_q;
	assign valid = valid_q;
	assign match = valid_q && key_q == key;
	assign free_out = free_in | ~valid_q;
	assign last_reported = rep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.sweep && valid_q && age >= remove_age) begin
			valid_q <= 1'b0;
		end else if (cmd.write && sel) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && sel) begin
			key_q <= key;
			heard_q <= now;
			rep_q <= now;
		end
		if (cmd.refresh && sel) begin
			heard_q <= now;
		end
		if (cmd.reported && sel) begin
			rep_q <= now;
		end
	end
endmodule

FILE: hdl/ftfta_chain.sv
module ftfta_chain #(
	parameter int FLOW_ENTRIES = ftfta_pkg::FLOW_ENTRIES_DEF,
	parameter int TIME_BITS = ftfta_pkg::TIME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input ftfta_pkg::cell_cmd_t cmd,
	input logic [FLOW_ENTRIES-1:0] sel,
	input ftfta_pkg::key_t key,
	input logic [TIME_BITS-1:0] now,
	input logic [TIME_BITS-1:0] remove_age,
	output logic [FLOW_ENTRIES-1:0] hit_vec,
	output logic [FLOW_ENTRIES-1:0] free_vec,
	output logic [TIME_BITS-1:0] rep_sel
);
	logic [FLOW_ENTRIES:0] free_chain;
	logic [FLOW_ENTRIES-1:0] valid_vec;
	logic [FLOW_ENTRIES-1:0] match_vec;
	logic [TIME_BITS-1:0] rep [FLOW_ENTRIES];
	logic [TIME_BITS-1:0] rep_or;

	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
		ftfta_cell #(.TIME_BITS(TIME_BITS)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.sel(sel[g]),
			.key(key),
			.now(now),
			.remove_age(remove_age),
			.free_in(free_chain[g]),
			.free_out(free_chain[g+1]),
			.valid(valid_vec[g]),
			.match(match_vec[g]),
			.last_reported(rep[g])
		);
		assign free_vec[g] = ~valid_vec[g] & ~free_chain[g];
		assign hit_vec[g] = match_vec[g];
	end

	always_comb begin
		rep_or = '0;
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			rep_or = rep_or | (sel[i] ? rep[i] : '0);
		end
	end
	assign rep_sel = rep_or;
endmodule

FILE: hdl/five_tuple_flow_table_with_aging_top.sv
// A packet item passes the match state, then the output state, which
// registers its result, if any; an item is accepted only when idle and
// no result waits. The tag compare across all cells is registered in the
// match state; first-hit/free selection and update follow in the output
// state. A sweep item gives no result. Reset (arst_n low, asynchronous)
// empties the table and loads the default report interval and remove age.
`include "five_tuple_flow_table_with_aging_top_defines.svh"
module five_tuple_flow_table_with_aging_top #(
	parameter int FLOW_ENTRIES = ftfta_pkg::FLOW_ENTRIES_DEF,
	parameter int TIME_BITS = ftfta_pkg::TIME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [ftfta_pkg::CFG_BITS-1:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// mode, now_us, ethertype, ip_protocol, source_address, dest_address,
	// source_port, dest_port; zero fill to whole bytes
	input logic [8*((1+TIME_BITS+16+8+32+32+16+16+7)/8)-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// flow_src_ip, flow_dst_ip, flow_protocol, flow_src_port,
	// flow_dst_port, new_flow, stored, 6 zero bits
	output logic [111:0] m_axis_tdata
);
	localparam int TB = TIME_BITS;

	ftfta_pkg::state_t state_q, state_d;
	logic [ftfta_pkg::CFG_BITS-1:0] rep_int_q, rem_age_q;
	logic mode_q;
	logic [TB-1:0] now_q;
	ftfta_pkg::key_t key_q;
	logic drop_q;
	logic [FLOW_ENTRIES-1:0] hit_s1, free_s1;
	logic [FLOW_ENTRIES-1:0] hit_vec, free_vec, first_hit, sel;
	logic [TB-1:0] rep_sel;
	logic any_hit, any_free, report;
	logic [TB-1:0] rep_age;
	ftfta_pkg::cell_cmd_t cmd;
	logic [111:0] out_q;
	logic ovalid_q;

	logic [15:0] in_eth;
	logic [7:0] in_proto;
	logic [15:0] in_sp, in_dp;
	logic ports_ok;

	assign in_eth = s_axis_tdata[TB+16:TB+1];
	assign in_proto = s_axis_tdata[TB+24:TB+17];
	assign ports_ok = in_proto == ftfta_pkg::PROTO_TCP || in_proto == ftfta_pkg::PROTO_UDP;
	assign in_sp = ports_ok ? s_axis_tdata[TB+104:TB+89] : 16'd0;
	assign in_dp = ports_ok ? s_axis_tdata[TB+120:TB+105] : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_int_q <= ftfta_pkg::REPORT_INTERVAL_RST;
			rem_age_q <= ftfta_pkg::REMOVE_AGE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftfta_pkg::REG_REPORT_INTERVAL: rep_int_q <= cfg_data;
				ftfta_pkg::REG_REMOVE_AGE: rem_age_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = state_q == ftfta_pkg::ST_IDLE && !ovalid_q;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_q <= s_axis_tdata[0];
			now_q <= s_axis_tdata[TB:1];
			key_q.sip <= s_axis_tdata[TB+56:TB+25];
			key_q.dip <= s_axis_tdata[TB+88:TB+57];
			key_q.proto <= in_proto;
			key_q.ports <= {in_sp, in_dp};
			drop_q <= in_eth != ftfta_pkg::ETHERTYPE_IPV4 ||
				(in_sp == 16'd0 && in_dp == 16'd0);
		end
		if (state_q == ftfta_pkg::ST_MATCH) begin
			hit_s1 <= hit_vec;
			free_s1 <= free_vec;
		end
	end

	always_comb begin
		first_hit = hit_s1 & ~(hit_s1 - FLOW_ENTRIES'(1));
		any_hit = |hit_s1;
		any_free = |free_s1;
		sel = '0;
		if (state_q == ftfta_pkg::ST_OUT) begin
			sel = any_hit ? first_hit : free_s1;
		end
		rep_age = now_q - rep_sel;
		cmd = '0;
		report = 1'b0;
		state_d = state_q;
		unique case (state_q)
			ftfta_pkg::ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) state_d = ftfta_pkg::ST_MATCH;
			end
			ftfta_pkg::ST_MATCH: begin
				cmd.sweep = mode_q;
				state_d = mode_q ? ftfta_pkg::ST_IDLE : ftfta_pkg::ST_OUT;
			end
			ftfta_pkg::ST_OUT: begin
				if (!drop_q) begin
					if (any_hit) begin
						cmd.refresh = 1'b1;
						report = rep_age > TB'(rep_int_q);
						cmd.reported = report;
					end else begin
						cmd.write = any_free;
						report = 1'b1;
					end
				end
				state_d = ftfta_pkg::ST_IDLE;
			end
			default: state_d = ftfta_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftfta_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (report) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			out_q <= {6'd0, any_hit | any_free, ~any_hit, key_q.ports[15:0],
				key_q.ports[31:16], key_q.proto, key_q.dip, key_q.sip};
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;

	ftfta_chain #(.FLOW_ENTRIES(FLOW_ENTRIES), .TIME_BITS(TIME_BITS)) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sel(sel),
		.key(key_q),
		.now(now_q),
		.remove_age(TB'(rem_age_q)),
		.hit_vec(hit_vec),
		.free_vec(free_vec),
		.rep_sel(rep_sel)
	);

	`FT_ASSERT(a_one_sel, clk, arst_n, $onehot0(sel), "more than one slot selected")
	`FT_ASSERT(a_no_accept_busy, clk, arst_n, state_q != ftfta_pkg::ST_IDLE |-> !s_axis_tready, "accept while busy")
	`FT_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result lost")
	`FT_ASSERT(a_report_state, clk, arst_n, report |-> state_q == ftfta_pkg::ST_OUT, "report outside output state")
endmodule

FILE: verif/tb_five_tuple_flow_table_with_aging_top.sv
module tb_five_tuple_flow_table_with_aging_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam logic [39:0] TMAX = 40'hFF_FFFF_FFFF;

	typedef struct {
		logic mode;
		logic [39:0] now;
		logic [15:0] eth;
		logic [7:0] proto;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
	} pkt_t;

	typedef struct {
		logic [31:0] sip;
		logic [31:0] dip;
		logic [7:0] proto;
		logic [15:0] sport;
		logic [15:0] dport;
		logic new_flow;
		logic stored;
	} report_t;

	class flow_table_model;
		logic [39:0] interval_us = ftfta_pkg::REPORT_INTERVAL_RST;
		logic [39:0] remove_us = ftfta_pkg::REMOVE_AGE_RST;
		bit used[SLOTS];
		logic [31:0] t_sip[SLOTS];
		logic [31:0] t_dip[SLOTS];
		logic [31:0] t_ports[SLOTS];
		logic [7:0] t_proto[SLOTS];
		logic [39:0] t_heard[SLOTS];
		logic [39:0] t_reported[SLOTS];
		report_t expected_reports[$];
		int errors = 0;

		function void set_reg(logic idx, logic [39:0] val);
			if (idx == ftfta_pkg::REG_REPORT_INTERVAL) interval_us = val;
			else remove_us = val;
		endfunction

		function void note_item(pkt_t p);
			logic [15:0] sp;
			logic [15:0] dp;
			logic [31:0] ports;
			int hit;
			int free;
			report_t r;
			sp = 0;
			dp = 0;
			hit = -1;
			free = -1;
			if (p.mode) begin
				for (int i = 0; i < SLOTS; i++)
					if (used[i] && 40'(p.now - t_heard[i]) >= remove_us) used[i] = 0;
				return;
			end
			if (p.eth != ftfta_pkg::ETHERTYPE_IPV4) return;
			if (p.proto == ftfta_pkg::PROTO_TCP || p.proto == ftfta_pkg::PROTO_UDP) begin
				sp = p.sport;
				dp = p.dport;
			end
			if (sp == 0 && dp == 0) return;
			ports = {sp, dp};
			for (int i = 0; i < SLOTS; i++) begin
				if (used[i]) begin
					if (hit < 0 && t_sip[i] == p.sip && t_dip[i] == p.dip &&
					    t_ports[i] == ports && t_proto[i] == p.proto) hit = i;
				end else if (free < 0) free = i;
			end
			r.sip = p.sip;
			r.dip = p.dip;
			r.proto = p.proto;
			r.sport = sp;
			r.dport = dp;
			if (hit >= 0) begin
				t_heard[hit] = p.now;
				if (40'(p.now - t_reported[hit]) <= interval_us) return;
				t_reported[hit] = p.now;
				r.new_flow = 0;
				r.stored = 1;
			end else begin
				r.new_flow = 1;
				r.stored = free >= 0;
				if (free >= 0) begin
					used[free] = 1;
					t_sip[free] = p.sip;
					t_dip[free] = p.dip;
					t_ports[free] = ports;
					t_proto[free] = p.proto;
					t_heard[free] = p.now;
					t_reported[free] = p.now;
				end
			end
			expected_reports.insert(expected_reports.size(), r);
		endfunction

		function void check_report(logic [111:0] d);
			report_t e;
			report_t a;
			a.sip = d[31:0];
			a.dip = d[63:32];
			a.proto = d[71:64];
			a.sport = d[87:72];
			a.dport = d[103:88];
			a.new_flow = d[104];
			a.stored = d[105];
			if (expected_reports.size() == 0) begin
				$display("%0t: expected no report, got %p", $time, a);
				errors++;
				return;
			end
			e = expected_reports.pop_front();
			if (a.sip != e.sip) begin
				$display("%0t: src_ip exp %h got %h", $time, e.sip, a.sip); errors++;
			end
			if (a.dip != e.dip) begin
				$display("%0t: dst_ip exp %h got %h", $time, e.dip, a.dip); errors++;
			end
			if (a.proto != e.proto) begin
				$display("%0t: protocol exp %0d got %0d", $time, e.proto, a.proto); errors++;
			end
			if (a.sport != e.sport) begin
				$display("%0t: sport exp %h got %h", $time, e.sport, a.sport); errors++;
			end
			if (a.dport != e.dport) begin
				$display("%0t: dport exp %h got %h", $time, e.dport, a.dport); errors++;
			end
			if (a.new_flow != e.new_flow) begin
				$display("%0t: new_flow exp %0d got %0d", $time, e.new_flow, a.new_flow);
				errors++;
			end
			if (a.stored != e.stored) begin
				$display("%0t: stored exp %0d got %0d", $time, e.stored, a.stored); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [ftfta_pkg::CFG_BITS-1:0] cfg_data = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [111:0] m_axis_tdata;

	flow_table_model flows = new();
	logic [39:0] cur_us = 40'd1000;
	bit no_gaps = 0;
	bit hold_off = 0;
	pkt_t flow_pool[96];

	five_tuple_flow_table_with_aging_top dut (.*);

	initial forever #10 clk = ~clk;

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	task automatic send_pkt(pkt_t p);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {7'b0, p.dport, p.sport, p.dip, p.sip, p.proto, p.eth, p.now, p.mode};
		s_axis_tvalid = 1;
		do @(posedge clk); while (!s_axis_tready);
		flows.note_item(p);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid = 0;
		while (flows.expected_reports.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [39:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		flows.set_reg(idx, val);
	endtask

	function automatic pkt_t flow_pkt(int k, logic [39:0] t);
		pkt_t p;
		p = flow_pool[k];
		p.now = t;
		return p;
	endfunction

	function automatic pkt_t sweep_pkt(logic [39:0] t);
		pkt_t p;
		p.mode = 1;
		p.now = t;
		p.eth = 16'($urandom);
		p.proto = 8'($urandom);
		p.sip = $urandom;
		p.dip = $urandom;
		p.sport = 16'($urandom);
		p.dport = 16'($urandom);
		return p;
	endfunction

	task automatic random_phase(int n, int max_step);
		pkt_t p;
		int r;
		for (int i = 0; i < n; i++) begin
			no_gaps = (i % 100) >= 80;
			cur_us += $urandom_range(0, max_step);
			r = $urandom_range(0, 99);
			if (r < 5) p = sweep_pkt(cur_us);
			else begin
				p = flow_pkt($urandom_range(0, 95), cur_us);
				if (r < 9) p.eth = 16'($urandom);
				else if (r < 12) p.proto = 8'($urandom);
				else if (r < 14) begin
					p.sport = 0;
					if ($urandom_range(0, 1)) p.dport = 0;
				end else if (r < 16) p.dport = 0;
			end
			send_pkt(p);
		end
	endtask

	initial begin
		for (int k = 0; k < 96; k++) begin
			flow_pool[k].mode = 0;
			flow_pool[k].eth = ftfta_pkg::ETHERTYPE_IPV4;
			flow_pool[k].proto = (k % 2) ? ftfta_pkg::PROTO_UDP : ftfta_pkg::PROTO_TCP;
			flow_pool[k].sip = $urandom;
			flow_pool[k].dip = $urandom;
			flow_pool[k].sport = 16'($urandom);
			flow_pool[k].dport = 16'($urandom);
		end
		flow_pool[0].sip = '1;
		flow_pool[0].dip = '1;
		flow_pool[0].sport = '1;
		flow_pool[0].dport = '1;
		flow_pool[1].sport = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		begin
			pkt_t p;
			send_pkt(flow_pkt(0, cur_us));
			send_pkt(flow_pkt(0, cur_us + 1000000));
			send_pkt(flow_pkt(0, cur_us + 4000000));
			send_pkt(flow_pkt(0, cur_us + 4000001));
			p = flow_pkt(2, cur_us); p.eth = 16'h86DD; send_pkt(p);
			p = flow_pkt(2, cur_us); p.eth = 16'hF7FF; send_pkt(p);
			p = flow_pkt(2, cur_us); p.proto = 8'd1; send_pkt(p);
			p = flow_pkt(3, cur_us); p.sport = 0; p.dport = 0; send_pkt(p);
			send_pkt(flow_pkt(1, cur_us));
			send_pkt(sweep_pkt(cur_us + 16000000));
			send_pkt(flow_pkt(0, cur_us + 16000001));
			send_pkt(sweep_pkt(cur_us + 20001000));
			cur_us = TMAX - 10;
			for (int k = 0; k < 66; k++) send_pkt(flow_pkt(k, cur_us + k));
			send_pkt(flow_pkt(0, 40'd5000000));
			send_pkt(sweep_pkt(40'd30000000));
			cur_us = 40'd30000000;
		end

		random_phase(300, 3000000);
		drain();
		write_reg(ftfta_pkg::REG_REPORT_INTERVAL, '0);
		write_reg(ftfta_pkg::REG_REMOVE_AGE, '0);
		hold_off = 1;
		random_phase(250, 2000);
		drain();
		write_reg(ftfta_pkg::REG_REPORT_INTERVAL, TMAX);
		write_reg(ftfta_pkg::REG_REMOVE_AGE, TMAX);
		cur_us = {8'($urandom_range(0, 255)), $urandom};
		random_phase(250, 200000);
		drain();
		write_reg(ftfta_pkg::REG_REPORT_INTERVAL, 40'd1000000);
		write_reg(ftfta_pkg::REG_REMOVE_AGE, 40'd3000000);
		cur_us = TMAX - 40'd100000000;
		random_phase(250, 1500000);
		drain();
		if (flows.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		int k;
		@(negedge clk);
		forever begin
			k = $urandom_range(0, 9);
			if (no_gaps) k = 0;
			if (hold_off) begin
				k = 300;
				hold_off = 0;
			end
			if (k > 0) begin
				m_axis_tready = 0;
				repeat (k) @(negedge clk);
			end
			m_axis_tready = 1;
			do @(posedge clk); while (!m_axis_tvalid);
			flows.check_report(m_axis_tdata);
			@(negedge clk);
		end
	end
endmodule

FILE: sim.f
+incdir+hdl
hdl/ftfta_pkg.sv
hdl/ftfta_cell.sv
hdl/ftfta_chain.sv
hdl/five_tuple_flow_table_with_aging_top.sv
verif/tb_five_tuple_flow_table_with_aging_top.sv
